>>> design/nls_pkg.sv
package nls_pkg;

	typedef enum logic [3:0] {
		PH_START    = 4'd0,
		PH_ZERO     = 4'd1,
		PH_OCT      = 4'd2,
		PH_OCTDEC   = 4'd3,
		PH_DEC      = 4'd4,
		PH_FRAC     = 4'd5,
		PH_EXPSIGN  = 4'd6,
		PH_EXPFIRST = 4'd7,
		PH_EXPDIG   = 4'd8,
		PH_HEX      = 4'd9,
		PH_HEXFRAC  = 4'd10,
		PH_SUFFIX   = 4'd11,
		PH_ERR      = 4'd12
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_OCT = 2'd1,
		RX_HEX = 2'd2
	} radix_t;

	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_DIGIT       = 3'd1,
		ERR_EMPTY_EXP   = 3'd2,
		ERR_HEX_NO_EXP  = 3'd3,
		ERR_SUFFIX      = 3'd4
	} err_t;

	typedef struct packed {
		logic digit;   // at least one octal digit after the leading zero
		logic flt;
		logic ll;
		logic lng;
		logic uns;
		logic expo;
		logic period;
	} flags_t;

	typedef struct packed {
		phase_t phase;
		radix_t radix;
		flags_t flags;
		logic   pend_valid;  // an l/L waits to see if it is ll
		logic   pend_upper;
		err_t   err;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		phase: PH_START,
		radix: RX_DEC,
		flags: '0,
		pend_valid: 1'b0,
		pend_upper: 1'b0,
		err: ERR_NONE
	};

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} char_word_t;

	typedef struct packed {
		logic [2:0]  error_code;
		logic [1:0]  radix_code;
		logic        is_floating;
		logic        has_period_flag;
		logic        has_exponent_flag;
		logic        unsigned_suffix;
		logic        long_suffix;
		logic        long_long_suffix;
		logic        float_suffix;
		logic [63:0] int_value;
		logic        value_overflow;
	} result_word_t;

	localparam int RESULT_VALUE_BITS = 64;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_8     = 8'h38;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_F_LO  = 8'h66;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_F_UP  = 8'h46;
	localparam logic [7:0] CH_E_LO  = 8'h65;
	localparam logic [7:0] CH_E_UP  = 8'h45;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_P_LO  = 8'h70;
	localparam logic [7:0] CH_P_UP  = 8'h50;
	localparam logic [7:0] CH_U_LO  = 8'h75;
	localparam logic [7:0] CH_U_UP  = 8'h55;
	localparam logic [7:0] CH_L_LO  = 8'h6c;
	localparam logic [7:0] CH_L_UP  = 8'h4c;

endpackage

>>> design/c_numeric_literal_scanner.sv
// Scans a C numeric literal one character per word and returns one result word
// on the word flagged last_char: error code, radix, period/exponent/suffix flags
// and the integer value modulo 2^VALUE_BITS with a sticky overflow bit. A
// character word is taken every cycle while char_stall is low. Each character
// passes through an input register and one pass of phase logic plus a shift-add
// of the value accumulator (x8, x10 or x16); the last one lands in the result
// register, which holds while the result is stalled, and result_valid rises with
// it. A stalled result stalls the character side after one more word.
module c_numeric_literal_scanner #(
	parameter int VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  nls_pkg::char_word_t   char_word,
	output logic                  result_valid,
	input  logic                  result_stall,
	output nls_pkg::result_word_t result_word
);

	logic                  valid_s1;
	nls_pkg::char_word_t   word_s1;
	logic                  advance;

	nls_pkg::scan_state_t  st_q;
	nls_pkg::scan_state_t  st_proc;
	nls_pkg::scan_state_t  st_fin;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  ovf_q;
	logic                  acc_en;
	logic [3:0]            dig;
	logic [VALUE_BITS-1:0] acc_new;
	logic                  ovf_new;
	logic [VALUE_BITS-1:0] acc_cur;
	logic                  ovf_cur;

	logic                  res_valid_q;
	nls_pkg::result_word_t res_q;
	nls_pkg::result_word_t res_d;
	logic                  ok;
	logic                  fp;

	assign advance    = valid_s1 && (!res_valid_q || !result_stall);
	assign char_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall)
			word_s1 <= char_word;
	end

	nls_step u_step (
		.st      (st_q),
		.ch      (word_s1.char_in),
		.st_proc (st_proc),
		.st_fin  (st_fin),
		.acc_en  (acc_en),
		.dig     (dig)
	);

	nls_accum #(
		.VALUE_BITS (VALUE_BITS)
	) u_accum (
		.acc      (acc_q),
		.radix    (st_proc.radix),
		.dig      (dig),
		.ovf      (ovf_q),
		.acc_next (acc_new),
		.ovf_next (ovf_new)
	);

	assign acc_cur = acc_en ? acc_new : acc_q;
	assign ovf_cur = acc_en ? ovf_new : ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= nls_pkg::SCAN_RESET;
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (advance) begin
			if (word_s1.last_char) begin
				st_q  <= nls_pkg::SCAN_RESET;
				acc_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				st_q  <= st_proc;
				acc_q <= acc_cur;
				ovf_q <= ovf_cur;
			end
		end
	end

	assign ok = (st_fin.err == nls_pkg::ERR_NONE);
	assign fp = st_fin.flags.period | st_fin.flags.expo;

	always_comb begin
		res_d.error_code        = st_fin.err;
		res_d.radix_code        = st_fin.radix;
		res_d.is_floating       = fp;
		res_d.has_period_flag   = st_fin.flags.period;
		res_d.has_exponent_flag = st_fin.flags.expo;
		res_d.unsigned_suffix   = st_fin.flags.uns;
		res_d.long_suffix       = st_fin.flags.lng;
		res_d.long_long_suffix  = st_fin.flags.ll;
		res_d.float_suffix      = st_fin.flags.flt;
		res_d.int_value         = (ok && !fp) ? nls_pkg::RESULT_VALUE_BITS'(acc_cur) : '0;
		res_d.value_overflow    = ok && !fp && ovf_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && word_s1.last_char) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.last_char)
			res_q <= res_d;
	end

	assign result_valid = res_valid_q;
	assign result_word  = res_q;

endmodule

>>> design/nls_accum.sv
module nls_accum #(
	parameter int VALUE_BITS = 64
) (
	input  logic [VALUE_BITS-1:0] acc,
	input  nls_pkg::radix_t       radix,
	input  logic [3:0]            dig,
	input  logic                  ovf,
	output logic [VALUE_BITS-1:0] acc_next,
	output logic                  ovf_next
);

	logic [VALUE_BITS+3:0] wide;
	logic [VALUE_BITS+3:0] prod;
	logic [VALUE_BITS+3:0] sum;

	assign wide = {4'b0000, acc};

	always_comb begin
		case (radix)
			nls_pkg::RX_HEX: prod = wide << 4;
			nls_pkg::RX_OCT: prod = wide << 3;
			default:         prod = (wide << 3) + (wide << 1);
		endcase
	end

	assign sum      = prod + {{VALUE_BITS{1'b0}}, dig};
	// anything above the value width means acc*r+d no longer fits
	assign ovf_next = ovf | (|sum[VALUE_BITS+3:VALUE_BITS]);
	assign acc_next = sum[VALUE_BITS-1:0];

endmodule

>>> design/nls_step.sv
module nls_step (
	input  nls_pkg::scan_state_t st,
	input  logic [7:0]           ch,
	output nls_pkg::scan_state_t st_proc,
	output nls_pkg::scan_state_t st_fin,
	output logic                 acc_en,
	output logic [3:0]           dig
);

	function automatic logic is_dec(input logic [7:0] c);
		return c inside {[nls_pkg::CH_0:nls_pkg::CH_9]};
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return c inside {[nls_pkg::CH_0:nls_pkg::CH_9], [nls_pkg::CH_A_LO:nls_pkg::CH_F_LO],
			[nls_pkg::CH_A_UP:nls_pkg::CH_F_UP]};
	endfunction

	function automatic logic is_fp(input nls_pkg::scan_state_t s);
		return s.flags.period | s.flags.expo;
	endfunction

	function automatic nls_pkg::scan_state_t fail(input nls_pkg::scan_state_t s,
			input nls_pkg::err_t code);
		nls_pkg::scan_state_t r;
		r = s;
		r.err = code;
		r.phase = nls_pkg::PH_ERR;
		return r;
	endfunction

	function automatic nls_pkg::scan_state_t suffix_char(input nls_pkg::scan_state_t s,
			input logic [7:0] c);
		nls_pkg::scan_state_t r;
		logic done;
		r = s;
		done = 1'b0;
		if (r.pend_valid) begin
			r.pend_valid = 1'b0;
			if (c == (r.pend_upper ? nls_pkg::CH_L_UP : nls_pkg::CH_L_LO)) begin
				done = 1'b1;
				if (is_fp(r))
					r = fail(r, nls_pkg::ERR_SUFFIX);
				else
					r.flags.ll = 1'b1;
			end else begin
				r.flags.lng = 1'b1;
			end
		end
		if (!done) begin
			if (c == nls_pkg::CH_U_LO || c == nls_pkg::CH_U_UP) begin
				if (is_fp(r) || r.flags.uns)
					r = fail(r, nls_pkg::ERR_SUFFIX);
				else
					r.flags.uns = 1'b1;
			end else if (c == nls_pkg::CH_L_LO || c == nls_pkg::CH_L_UP) begin
				if (r.flags.lng || r.flags.ll) begin
					r = fail(r, nls_pkg::ERR_SUFFIX);
				end else begin
					r.pend_valid = 1'b1;
					r.pend_upper = (c == nls_pkg::CH_L_UP);
				end
			end else if (c == nls_pkg::CH_F_LO || c == nls_pkg::CH_F_UP) begin
				if (!is_fp(r) || r.flags.flt)
					r = fail(r, nls_pkg::ERR_SUFFIX);
				else
					r.flags.flt = 1'b1;
			end else begin
				r = fail(r, nls_pkg::ERR_SUFFIX);
			end
		end
		return r;
	endfunction

	function automatic nls_pkg::scan_state_t enter_suffix(input nls_pkg::scan_state_t s,
			input logic [7:0] c);
		nls_pkg::scan_state_t r;
		r = s;
		if (r.radix == nls_pkg::RX_OCT && !r.flags.digit)
			r.radix = nls_pkg::RX_DEC;
		r.phase = nls_pkg::PH_SUFFIX;
		return suffix_char(r, c);
	endfunction

	// first byte past the integer digits of a decimal or octal literal
	function automatic nls_pkg::scan_state_t after_int(input nls_pkg::scan_state_t s,
			input logic [7:0] c);
		nls_pkg::scan_state_t r;
		r = s;
		if (is_hex(c) && c != nls_pkg::CH_E_LO && c != nls_pkg::CH_E_UP) begin
			r = fail(r, nls_pkg::ERR_DIGIT);
		end else if (c == nls_pkg::CH_DOT) begin
			r.flags.period = 1'b1;
			r.radix = nls_pkg::RX_DEC;
			r.phase = nls_pkg::PH_FRAC;
		end else if (c == nls_pkg::CH_E_LO || c == nls_pkg::CH_E_UP) begin
			r.radix = nls_pkg::RX_DEC;
			r.flags.expo = 1'b1;
			r.phase = nls_pkg::PH_EXPSIGN;
		end else begin
			r = enter_suffix(r, c);
		end
		return r;
	endfunction

	nls_pkg::scan_state_t s;
	nls_pkg::scan_state_t f;
	logic                 taken;
	logic                 is_e;
	logic                 is_p;

	assign is_e = (ch == nls_pkg::CH_E_LO) || (ch == nls_pkg::CH_E_UP);
	assign is_p = (ch == nls_pkg::CH_P_LO) || (ch == nls_pkg::CH_P_UP);
	// digit value: letters a-f/A-F have low nibble 1..6
	assign dig  = ch[6] ? ch[3:0] + 4'd9 : ch[3:0];

	always_comb begin
		s = st;
		taken = 1'b0;
		acc_en = 1'b0;
		// the leading-zero phases hand the same byte on to the digit phases
		if (s.phase == nls_pkg::PH_START) begin
			if (ch == nls_pkg::CH_0) begin
				s.radix = nls_pkg::RX_OCT;
				s.phase = nls_pkg::PH_ZERO;
				taken = 1'b1;
			end else begin
				s.radix = nls_pkg::RX_DEC;
				s.phase = nls_pkg::PH_DEC;
			end
		end else if (s.phase == nls_pkg::PH_ZERO) begin
			if (ch == nls_pkg::CH_X_LO || ch == nls_pkg::CH_X_UP) begin
				s.radix = nls_pkg::RX_HEX;
				s.phase = nls_pkg::PH_HEX;
				taken = 1'b1;
			end else begin
				s.phase = nls_pkg::PH_OCT;
			end
		end
		if (!taken) begin
			case (s.phase)
				nls_pkg::PH_OCT: begin
					if (ch inside {[nls_pkg::CH_0:nls_pkg::CH_7]}) begin
						s.flags.digit = 1'b1;
						acc_en = 1'b1;
					end else if (ch == nls_pkg::CH_8 || ch == nls_pkg::CH_9) begin
						s.phase = nls_pkg::PH_OCTDEC;
					end else begin
						s = after_int(s, ch);
					end
				end
				nls_pkg::PH_OCTDEC: begin
					if (!is_dec(ch)) begin
						if (ch == nls_pkg::CH_DOT || is_e) begin
							s.radix = nls_pkg::RX_DEC;
							s = after_int(s, ch);
						end else begin
							s = fail(s, nls_pkg::ERR_DIGIT);
						end
					end
				end
				nls_pkg::PH_DEC: begin
					if (is_dec(ch))
						acc_en = 1'b1;
					else
						s = after_int(s, ch);
				end
				nls_pkg::PH_FRAC: begin
					if (!is_dec(ch)) begin
						if (is_e) begin
							s.flags.expo = 1'b1;
							s.phase = nls_pkg::PH_EXPSIGN;
						end else begin
							s = enter_suffix(s, ch);
						end
					end
				end
				nls_pkg::PH_EXPSIGN: begin
					if (ch == nls_pkg::CH_PLUS || ch == nls_pkg::CH_MINUS)
						s.phase = nls_pkg::PH_EXPFIRST;
					else if (is_dec(ch))
						s.phase = nls_pkg::PH_EXPDIG;
					else
						s = fail(s, nls_pkg::ERR_EMPTY_EXP);
				end
				nls_pkg::PH_EXPFIRST: begin
					if (is_dec(ch))
						s.phase = nls_pkg::PH_EXPDIG;
					else
						s = fail(s, nls_pkg::ERR_EMPTY_EXP);
				end
				nls_pkg::PH_EXPDIG: begin
					if (!is_dec(ch))
						s = enter_suffix(s, ch);
				end
				nls_pkg::PH_HEX: begin
					if (is_hex(ch)) begin
						acc_en = 1'b1;
					end else if (ch == nls_pkg::CH_DOT) begin
						s.flags.period = 1'b1;
						s.phase = nls_pkg::PH_HEXFRAC;
					end else if (is_p) begin
						s.flags.expo = 1'b1;
						s.phase = nls_pkg::PH_EXPSIGN;
					end else begin
						s = enter_suffix(s, ch);
					end
				end
				nls_pkg::PH_HEXFRAC: begin
					if (!is_hex(ch)) begin
						if (is_p) begin
							s.flags.expo = 1'b1;
							s.phase = nls_pkg::PH_EXPSIGN;
						end else begin
							s = fail(s, nls_pkg::ERR_HEX_NO_EXP);
						end
					end
				end
				nls_pkg::PH_SUFFIX: begin
					s = suffix_char(s, ch);
				end
				default: begin
				end
			endcase
		end
		// errors freeze everything until the end of the token
		if (st.phase == nls_pkg::PH_ERR) begin
			s = st;
			acc_en = 1'b0;
		end
	end

	assign st_proc = s;

	// end-of-token checks
	always_comb begin
		f = s;
		case (s.phase)
			nls_pkg::PH_ZERO, nls_pkg::PH_OCT: begin
				if (!s.flags.digit)
					f.radix = nls_pkg::RX_DEC;
			end
			nls_pkg::PH_OCTDEC:  f = fail(s, nls_pkg::ERR_DIGIT);
			nls_pkg::PH_HEXFRAC: f = fail(s, nls_pkg::ERR_HEX_NO_EXP);
			nls_pkg::PH_EXPSIGN, nls_pkg::PH_EXPFIRST: f = fail(s, nls_pkg::ERR_EMPTY_EXP);
			default: begin
			end
		endcase
		if (f.err == nls_pkg::ERR_NONE && f.pend_valid)
			f.flags.lng = 1'b1;
		f.pend_valid = 1'b0;
	end

	assign st_fin = f;

endmodule

>>> design/nls_checker.sv
module nls_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  char_stall,
	input logic                  result_valid,
	input logic                  result_stall,
	input nls_pkg::result_word_t result_word
);

	logic value_zero;

	assign value_zero = (result_word.int_value == '0) && !result_word.value_overflow;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_word))
		else $error("stalled result word changed");

	// the character side only backs up behind a held result
	a_no_spurious_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !char_stall)
		else $error("char stall without a pending result");

	a_value_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_word.is_floating ||
			result_word.error_code != nls_pkg::ERR_NONE) |-> value_zero)
		else $error("value reported on floating or failed literal");

	a_floating_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_word.is_floating ==
			(result_word.has_period_flag || result_word.has_exponent_flag))
		else $error("floating flag disagrees with period/exponent");

	a_suffix_sane: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result_word.long_suffix && result_word.long_long_suffix) &&
			(!result_word.float_suffix || result_word.is_floating))
		else $error("inconsistent suffix flags");

endmodule

bind c_numeric_literal_scanner nls_checker u_nls_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.char_stall   (char_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_word  (result_word)
);
